### rtl/idq_pkg.sv
// Shared types, codes and sizes for the indexed double-ended queue.
package idq_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [OP_W-1:0] OP_INS_BACK   = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_IDX   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_IDX  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } idq_cmd_t;

endpackage

### rtl/idq_ctrl.sv
// Controller state machine: capture, execute, present.
module idq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output idq_pkg::idq_cmd_t cmd
);
  import idq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted word got no result two cycles later");

  a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("execute step did not follow capture");

endmodule

### rtl/idq_dpath.sv
// Datapath: ring store, head pointer, fill count and result registers.
module idq_dpath #(
  parameter int CAPACITY   = idq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  idq_pkg::idq_cmd_t  cmd,
  input  idq_pkg::in_word_t  in_item,
  output idq_pkg::out_word_t out_item
);
  import idq_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LOG_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  in_word_t              in_r;
  logic [PTR_W-1:0]      head_r;
  logic [PTR_W-1:0]      head_nxt;
  logic [CNT_W-1:0]      fill_r;
  logic [CNT_W-1:0]      fill_nxt;
  logic [DATA_WIDTH-1:0] rd_r;
  logic                  rd_ok_r;
  logic                  rd_ok_nxt;
  logic [STATUS_W-1:0]   status_r;
  logic [STATUS_W-1:0]   status_nxt;

  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic [PTR_W-1:0]      head_dec;
  logic [LOG_W-1:0]      logical;
  logic [PTR_W:0]        ring_sum;
  logic [PTR_W-1:0]      ring_addr;
  logic [PTR_W-1:0]      addr;
  logic                  we;

  assign full     = (fill_r == CNT_W'(CAPACITY));
  assign empty    = (fill_r == '0);
  assign pos_ok   = (LOG_W'(in_r.position) < LOG_W'(fill_r));
  assign head_dec = (head_r == '0) ? PTR_W'(CAPACITY - 1) : head_r - 1'b1;

  // pick the logical index, then wrap head + index once
  always_comb begin
    case (in_r.operation)
      OP_INS_BACK:  logical = LOG_W'(fill_r);
      OP_READ_BACK: logical = LOG_W'(fill_r) - 1'b1;
      OP_READ_IDX,
      OP_WRITE_IDX: logical = LOG_W'(in_r.position);
      default:      logical = '0;
    endcase
  end

  assign ring_sum  = {1'b0, head_r} + {1'b0, logical[PTR_W-1:0]};
  assign ring_addr = (ring_sum >= (PTR_W+1)'(CAPACITY)) ?
                     PTR_W'(ring_sum - (PTR_W+1)'(CAPACITY)) : ring_sum[PTR_W-1:0];

  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    we         = 1'b0;
    addr       = ring_addr;
    case (in_r.operation)
      OP_INS_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we       = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_INS_FRONT: begin
        addr = head_dec;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we       = 1'b1;
          head_nxt = head_dec;
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_READ_IDX: begin
        if (pos_ok) begin
          rd_ok_nxt = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_WRITE_IDX: begin
        if (pos_ok) begin
          we = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_READ_FRONT,
      OP_READ_BACK: begin
        if (empty) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (we) begin
        mem[addr] <= DATA_WIDTH'(in_r.value);
      end
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      fill_r   <= '0;
      rd_ok_r  <= 1'b0;
      status_r <= ST_OK;
    end else if (cmd.exec) begin
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      rd_ok_r  <= rd_ok_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_item.data     = rd_ok_r ? VALUE_W'(rd_r) : '0;
  assign out_item.status   = status_r;
  assign out_item.count    = COUNT_W'(fill_r);
  assign out_item.is_empty = empty;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count past capacity");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && full) |=> (fill_r == $past(fill_r)) && (head_r == $past(head_r)))
    else $error("operation on a full store moved the pointers");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> (fill_r == $past(fill_r)) && (head_r == $past(head_r)))
    else $error("pointers moved outside the execute step");

endmodule

### rtl/indexed_double_ended_queue.sv
// Top level of the indexed double-ended queue: controller plus datapath.
//
// Usage: drive in_item and raise start; the word is taken at a rising edge
// where start is high and busy is low. Each word is one operation: push
// back, push front, read or write at a logical index, read front or read
// back. Exactly one result word follows, shown on out_item for one cycle
// with out_valid high, carrying the data read (zero otherwise), a status
// (ok, out of range or empty, full), the element count and an empty flag.
// Sequence: after the accepting edge the controller passes through the
// execute state and then raises out_valid in the result state.
// Busy stays high through the execute step, where the ring memory is read
// or written at one address, and the result step, so a new word is taken
// only after the previous result has been shown.
// Reset (rst_n low at a clock edge) empties the queue and returns the
// controller to idle; stored elements are not cleared and need no pass.
// The receiver cannot hold results off: each strobe is taken as shown.
module indexed_double_ended_queue #(
  parameter int CAPACITY   = idq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  idq_pkg::in_word_t  in_item,
  output logic               out_valid,
  output idq_pkg::out_word_t out_item
);
  import idq_pkg::*;

  idq_cmd_t cmd;

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  idq_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

### sim/indexed_double_ended_queue_tb.sv
// Self-checking testbench for the indexed double-ended queue.
module indexed_double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idq_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;

  localparam int STALL_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 6;
  localparam int RANDOM_PER_PHASE = 258;
  localparam int IDLE_PCT [4]     = '{0, 79, 0, 20};

  class idq_scoreboard;
    logic [VALUE_W-1:0] ring [CAPACITY_DEF];
    logic [POS_W-1:0]   head;
    logic [COUNT_W-1:0] fill;
    out_word_t          expected_results[$];
    int                 mismatches;

    function new();
      head = '0;
      fill = '0;
      mismatches = 0;
    endfunction

    // Compute the result word of one operation and advance the queue state.
    function out_word_t predict_result(in_word_t w);
      out_word_t        r;
      logic [POS_W-1:0] slot;
      r = '0;
      r.status = ST_OK;
      case (w.operation)
        OP_INS_BACK, OP_INS_FRONT: begin
          if (fill == CAPACITY_DEF) begin
            r.status = ST_FULL;
          end else begin
            if (w.operation == OP_INS_FRONT) begin
              head = head - 1'b1;
              slot = head;
            end else begin
              slot = head + fill[POS_W-1:0];
            end
            ring[slot] = w.value;
            fill = fill + 1'b1;
          end
        end
        OP_READ_IDX, OP_WRITE_IDX: begin
          if ({1'b0, w.position} >= fill) begin
            r.status = ST_RANGE;
          end else begin
            slot = head + w.position;
            if (w.operation == OP_READ_IDX) r.data = ring[slot];
            else ring[slot] = w.value;
          end
        end
        OP_READ_FRONT, OP_READ_BACK: begin
          if (fill == 0) begin
            r.status = ST_RANGE;
          end else begin
            // a full ring has zero in the low bits of fill here, so back lands at head - 1
            slot = (w.operation == OP_READ_FRONT) ? head : head + fill[POS_W-1:0] - 1'b1;
            r.data = ring[slot];
          end
        end
        default: r.status = ST_RANGE;
      endcase
      r.count = fill;
      r.is_empty = (fill == 0);
      return r;
    endfunction

    function void note_operation(in_word_t w);
      expected_results.insert(expected_results.size(), predict_result(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.data !== want.data || got.status !== want.status ||
          got.count !== want.count || got.is_empty !== want.is_empty) begin
        $display("%0t: mismatch: expected data %h status %0d count %0d empty %0b",
                 $time, want.data, want.status, want.count, want.is_empty);
        $display("%0t:           actual   data %h status %0d count %0d empty %0b",
                 $time, got.data, got.status, got.count, got.is_empty);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_item;
  logic        out_valid;
  out_word_t   out_item;
  int unsigned quiet_cycles = 0;

  idq_scoreboard sb;

  indexed_double_ended_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the word until the block takes it; leave start high for a follow-up.
  task automatic send_word(input in_word_t w);
    in_item <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_operation(w);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VALUE_W-1:0] val);
    in_word_t w;
    w.operation = op;
    w.position = pos;
    w.value = val;
    send_word(w);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 18)      w.operation = OP_INS_BACK;
    else if (pick < 36) w.operation = OP_INS_FRONT;
    else if (pick < 56) w.operation = OP_READ_IDX;
    else if (pick < 76) w.operation = OP_WRITE_IDX;
    else if (pick < 85) w.operation = OP_READ_FRONT;
    else if (pick < 94) w.operation = OP_READ_BACK;
    else if (pick < 97) w.operation = OP_RESERVED_6;
    else                w.operation = OP_RESERVED_7;
    // mostly in range, with the first index past the end now and then
    if (sb.fill == 0 || $urandom_range(0, 7) == 0)
      w.position = POS_W'($urandom_range(0, 255));
    else
      w.position = POS_W'($urandom_range(0, (sb.fill > 255) ? 255 : sb.fill));
    if ($urandom_range(0, 15) == 0)
      w.value = $urandom_range(0, 1) ? '1 : '0;
    else
      w.value = $urandom();
    return w;
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: every read and write must fail; then pushes at both ends and index checks
    send_op(OP_READ_FRONT, 8'd0, 32'h0);
    send_op(OP_READ_BACK, 8'd0, 32'h0);
    send_op(OP_READ_IDX, 8'd0, 32'h0);
    send_op(OP_WRITE_IDX, 8'd0, 32'hFFFF_FFFF);
    send_op(OP_RESERVED_6, 8'd0, 32'h0);
    send_op(OP_RESERVED_7, 8'hFF, 32'hFFFF_FFFF);
    send_op(OP_INS_BACK, 8'd0, 32'h0000_0000);
    send_op(OP_INS_BACK, 8'hFF, 32'hFFFF_FFFF);
    send_op(OP_INS_FRONT, 8'd0, 32'h5A5A_A5A5);
    send_op(OP_INS_FRONT, 8'd0, 32'hA5A5_5A5A);
    send_op(OP_READ_IDX, 8'd0, 32'h0);
    send_op(OP_READ_IDX, 8'd3, 32'h0);
    send_op(OP_READ_IDX, 8'd4, 32'h0);
    send_op(OP_READ_IDX, 8'hFF, 32'h0);
    send_op(OP_WRITE_IDX, 8'd3, 32'h1234_5678);
    send_op(OP_WRITE_IDX, 8'd4, 32'hDEAD_BEEF);
    send_op(OP_WRITE_IDX, 8'hFF, 32'hDEAD_BEEF);
    send_op(OP_READ_FRONT, 8'd0, 32'h0);
    send_op(OP_READ_BACK, 8'd0, 32'h0);
    send_op(OP_READ_IDX, 8'd3, 32'h0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        while ($urandom_range(0, 99) < IDLE_PCT[ph]) begin
          start <= 1'b0;
          @(posedge clk);
        end
        send_word(make_random_word());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/idq_pkg.sv
rtl/idq_ctrl.sv
rtl/idq_dpath.sv
rtl/indexed_double_ended_queue.sv
sim/indexed_double_ended_queue_tb.sv
